[hdl/pei_pkg.sv]
// Shared types and constants for the particle Euler integrator.
`default_nettype none
package pei_pkg;

  localparam int OP_W = 2;
  localparam int STEP_W = 4;
  localparam int FACTOR_W = 31;
  localparam int DAMP_BITS = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [OP_W-1:0] OP_FORCE = 2'd0;
  localparam logic [OP_W-1:0] OP_INTEG = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_POS = 2'd2;
  localparam logic [OP_W-1:0] OP_SET_VEL = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_INV_MASS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_Y = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_Z = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING = 3'd5;

  localparam logic [STEP_W-1:0] ST_MUL_VEL = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_FORCE = 4'd1;
  localparam logic [STEP_W-1:0] ST_POS = 4'd2;
  localparam logic [STEP_W-1:0] ST_ACC = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_ACC = 4'd4;
  localparam logic [STEP_W-1:0] ST_RND_ACC = 4'd5;
  localparam logic [STEP_W-1:0] ST_VEL = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_DAMP = 4'd7;
  localparam logic [STEP_W-1:0] ST_DAMP = 4'd8;

  typedef struct packed {
    logic load;
    logic step_en;
    logic [STEP_W-1:0] step;
    logic [OP_W-1:0] op;
  } lane_ctl_t;

endpackage
`default_nettype wire

[hdl/pei_lane.sv]
// One axis lane: state words, a split multiplier with rounding, and a saturating adder.
`default_nettype none
module pei_lane #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_WIDTH = 32
) (
  input wire clk,
  input wire rst,
  input wire pei_pkg::lane_ctl_t ctl,
  input wire [31:0] vec_in,
  input wire [31:0] accel_in,
  input wire [30:0] inv_mass,
  input wire [16:0] time_step,
  input wire [16:0] damping,
  output logic [31:0] pos_out,
  output logic [31:0] vel_out,
  output logic sat_out
);

  localparam int W = WORD_WIDTH;
  localparam int FW = pei_pkg::FACTOR_W;
  localparam int LO_W = (W + 1) / 2;
  localparam int HI_W = W - LO_W;
  localparam int PW = W + FW;
  localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW:0] LIM_POS = (PW+1)'(WORD_MAX);
  localparam logic [PW:0] LIM_NEG = LIM_POS + (PW+1)'(1);
  localparam logic [PW:0] HALF_F = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] HALF_D = (PW+1)'(1) << (pei_pkg::DAMP_BITS - 1);
  localparam logic signed [63:0] MAX64 = 64'(signed'(WORD_MAX));
  localparam logic signed [63:0] MIN64 = 64'(signed'(WORD_MIN));

  function automatic logic [W:0] clip_in(input logic [31:0] x);
    logic signed [63:0] xe;
    xe = 64'(signed'(x));
    if (xe > MAX64) begin
      return {1'b1, WORD_MAX};
    end else if (xe < MIN64) begin
      return {1'b1, WORD_MIN};
    end
    return {1'b0, xe[W-1:0]};
  endfunction

  function automatic logic [31:0] to_out(input logic signed [W-1:0] x);
    logic signed [63:0] xe;
    xe = 64'(x);
    return xe[31:0];
  endfunction

  logic signed [W-1:0] pos;
  logic signed [W-1:0] vel;
  logic signed [W-1:0] force_acc;
  logic signed [W-1:0] prod;
  logic signed [W-1:0] acc;
  logic signed [W-1:0] vin;
  logic sat;

  logic m_neg;
  logic m_damp;
  logic [HI_W+FW-1:0] m_hi_p;
  logic [LO_W+FW-1:0] m_lo_p;

  logic [W:0] in_clip;
  logic [W:0] accel_clip;
  logic signed [W-1:0] accel;

  logic signed [W-1:0] mul_a;
  logic [FW-1:0] mul_f;
  logic mul_damp;
  logic [W-1:0] mul_mag;

  logic [PW:0] rnd_full;
  logic [PW:0] rnd_shift;
  logic [PW:0] rnd_lim;
  logic [W-1:0] rnd_mag;
  logic signed [W-1:0] rnd_val;
  logic rnd_sat;

  logic signed [W-1:0] add_a;
  logic signed [W-1:0] add_b;
  logic signed [W:0] add_sum;
  logic signed [W-1:0] add_val;
  logic add_sat;

  assign in_clip = clip_in(vec_in);
  assign accel_clip = clip_in(accel_in);
  assign accel = accel_clip[W-1:0];

  always_comb begin
    mul_a = vel;
    mul_f = FW'(time_step);
    mul_damp = 1'b0;
    case (ctl.step)
      pei_pkg::ST_MUL_VEL: begin
        mul_a = vel;
        mul_f = FW'(time_step);
      end
      pei_pkg::ST_MUL_FORCE: begin
        mul_a = force_acc;
        mul_f = inv_mass;
      end
      pei_pkg::ST_MUL_ACC: begin
        mul_a = acc;
        mul_f = FW'(time_step);
      end
      pei_pkg::ST_MUL_DAMP: begin
        mul_a = acc;
        mul_f = FW'(damping);
        mul_damp = 1'b1;
      end
      default: begin
        mul_a = vel;
        mul_f = FW'(time_step);
      end
    endcase
    mul_mag = mul_a[W-1] ? W'(0) - mul_a : mul_a;
  end

  always_ff @(posedge clk) begin
    m_neg <= mul_a[W-1];
    m_damp <= mul_damp;
    m_hi_p <= (HI_W+FW)'(mul_mag[W-1:LO_W]) * (HI_W+FW)'(mul_f);
    m_lo_p <= (LO_W+FW)'(mul_mag[LO_W-1:0]) * (LO_W+FW)'(mul_f);
  end

  always_comb begin
    rnd_full = ((PW+1)'(m_hi_p) << LO_W) + (PW+1)'(m_lo_p) + (m_damp ? HALF_D : HALF_F);
    rnd_shift = m_damp ? (rnd_full >> pei_pkg::DAMP_BITS) : (rnd_full >> FRAC_BITS);
    rnd_lim = m_neg ? LIM_NEG : LIM_POS;
    if (rnd_shift > rnd_lim) begin
      rnd_sat = 1'b1;
      rnd_mag = rnd_lim[W-1:0];
    end else begin
      rnd_sat = 1'b0;
      rnd_mag = rnd_shift[W-1:0];
    end
    rnd_val = m_neg ? W'(0) - rnd_mag : rnd_mag;
  end

  always_comb begin
    add_a = force_acc;
    add_b = vin;
    case (ctl.step)
      pei_pkg::ST_POS: begin
        add_a = pos;
        add_b = prod;
      end
      pei_pkg::ST_ACC: begin
        add_a = accel;
        add_b = prod;
      end
      pei_pkg::ST_VEL: begin
        add_a = vel;
        add_b = prod;
      end
      default: begin
        add_a = force_acc;
        add_b = vin;
      end
    endcase
    add_sum = (W+1)'(add_a) + (W+1)'(add_b);
    if (add_sum[W] != add_sum[W-1]) begin
      add_sat = 1'b1;
      add_val = add_sum[W] ? WORD_MIN : WORD_MAX;
    end else begin
      add_sat = 1'b0;
      add_val = add_sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
      force_acc <= '0;
      sat <= 1'b0;
    end else if (ctl.load) begin
      vin <= in_clip[W-1:0];
      sat <= in_clip[W];
    end else if (ctl.step_en) begin
      case (ctl.op)
        pei_pkg::OP_FORCE: begin
          force_acc <= add_val;
          sat <= sat | add_sat;
        end
        pei_pkg::OP_SET_POS: begin
          pos <= vin;
        end
        pei_pkg::OP_SET_VEL: begin
          vel <= vin;
        end
        pei_pkg::OP_INTEG: begin
          case (ctl.step)
            pei_pkg::ST_MUL_FORCE, pei_pkg::ST_RND_ACC: begin
              prod <= rnd_val;
              sat <= sat | rnd_sat;
            end
            pei_pkg::ST_POS: begin
              pos <= add_val;
              prod <= rnd_val;
              sat <= sat | add_sat | rnd_sat;
            end
            pei_pkg::ST_ACC, pei_pkg::ST_VEL: begin
              acc <= add_val;
              sat <= sat | add_sat;
            end
            pei_pkg::ST_DAMP: begin
              vel <= rnd_val;
              force_acc <= '0;
              sat <= sat | rnd_sat;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_out = to_out(pos);
  assign vel_out = to_out(vel);
  assign sat_out = sat;

endmodule
`default_nettype wire

[hdl/pei_merge.sv]
// Output stage that combines the three lanes into one result word.
`default_nettype none
module pei_merge (
  input wire clk,
  input wire rst,
  input wire load,
  input wire [2:0][31:0] lane_pos,
  input wire [2:0][31:0] lane_vel,
  input wire [2:0] lane_sat,
  input wire out_stall,
  output logic out_valid,
  output logic [2:0][31:0] pos,
  output logic [2:0][31:0] vel,
  output logic saturated
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos <= lane_pos;
      vel <= lane_vel;
      saturated <= |lane_sat;
    end
  end

endmodule
`default_nettype wire

[hdl/particle_euler_integrator_top.sv]
// Top level of the particle Euler integrator: configuration, sequencer and lanes.
// Force, loads and an integrate at zero inverse mass run only the first lane step.
// A full integrate runs nine lane steps; every command ends with the output load.
// The input takes no new word until the last result is loaded; output stalls delay that.
// Synchronous reset clears position, velocity and force and restores the register defaults.
`default_nettype none
module particle_euler_integrator_top #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_WIDTH = 32
) (
  input wire clk,
  input wire rst,
  input wire in_valid,
  output logic in_stall,
  input wire [1:0] opcode,
  input wire signed [31:0] vec_x,
  input wire signed [31:0] vec_y,
  input wire signed [31:0] vec_z,
  output logic out_valid,
  input wire out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic saturated,
  input wire cfg_valid,
  output logic cfg_ready,
  input wire [2:0] cfg_index,
  input wire [31:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [30:0] inverse_mass;
  logic [2:0][31:0] accel;
  logic [16:0] time_step;
  logic [16:0] damping_factor;

  logic [1:0] state;
  logic [pei_pkg::STEP_W-1:0] step;
  logic [pei_pkg::OP_W-1:0] op;
  logic [pei_pkg::STEP_W-1:0] last_step;
  logic in_accept;
  logic emit;
  pei_pkg::lane_ctl_t ctl;

  logic [2:0][31:0] vec_in;
  logic [2:0][31:0] lane_pos;
  logic [2:0][31:0] lane_vel;
  logic [2:0] lane_sat;
  logic [2:0][31:0] res_pos;
  logic [2:0][31:0] res_vel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mass <= 31'd65536;
      accel <= '0;
      time_step <= 17'd1092;
      damping_factor <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pei_pkg::REG_INV_MASS: inverse_mass <= cfg_data[30:0];
        pei_pkg::REG_ACCEL_X: accel[0] <= cfg_data;
        pei_pkg::REG_ACCEL_Y: accel[1] <= cfg_data;
        pei_pkg::REG_ACCEL_Z: accel[2] <= cfg_data;
        pei_pkg::REG_TIME_STEP: time_step <= cfg_data[16:0];
        pei_pkg::REG_DAMPING: damping_factor <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit = (state == S_EMIT) && (!out_valid || !out_stall);
  assign last_step = (op == pei_pkg::OP_INTEG && inverse_mass != 31'd0) ?
                     pei_pkg::ST_DAMP : pei_pkg::ST_MUL_VEL;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      op <= pei_pkg::OP_FORCE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_RUN;
            step <= pei_pkg::ST_MUL_VEL;
            op <= opcode;
          end
        end
        S_RUN: begin
          if (step == last_step) begin
            state <= S_EMIT;
          end else begin
            step <= step + pei_pkg::STEP_W'(1);
          end
        end
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.load = in_accept;
    ctl.step_en = (state == S_RUN);
    ctl.step = step;
    ctl.op = op;
  end

  assign vec_in = {vec_z, vec_y, vec_x};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pei_lane #(
      .FRAC_BITS(FRAC_BITS),
      .WORD_WIDTH(WORD_WIDTH)
    ) u_lane (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .vec_in(vec_in[i]),
      .accel_in(accel[i]),
      .inv_mass(inverse_mass),
      .time_step(time_step),
      .damping(damping_factor),
      .pos_out(lane_pos[i]),
      .vel_out(lane_vel[i]),
      .sat_out(lane_sat[i])
    );
  end

  pei_merge u_merge (
    .clk(clk),
    .rst(rst),
    .load(emit),
    .lane_pos(lane_pos),
    .lane_vel(lane_vel),
    .lane_sat(lane_sat),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .pos(res_pos),
    .vel(res_vel),
    .saturated(saturated)
  );

  assign pos_x = res_pos[0];
  assign pos_y = res_pos[1];
  assign pos_z = res_pos[2];
  assign vel_x = res_vel[0];
  assign vel_y = res_vel[1];
  assign vel_z = res_vel[2];

endmodule
`default_nettype wire

[verif/particle_euler_integrator_top_tb.sv]
// Self-checking testbench for the particle Euler integrator with its own fixed-point model.
module particle_euler_integrator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic [pei_pkg::OP_W-1:0] op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } motion_cmd_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic saturated;
  } motion_state_t;

  localparam wide_t WORD_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t WORD_LO = -64'sh0000_0000_8000_0000;
  localparam int SCALE_BITS = 16;
  localparam int MILD_SPAN = 1 << 20;
  localparam logic [pei_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pei_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  motion_cmd_t pending_cmds[$];
  motion_state_t expected_states[$];
  motion_cmd_t next_cmd;
  motion_state_t want;
  motion_state_t got;
  int issued_count = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic [63:0] inv_mass_reg = 64'd65536;
  logic [63:0] time_step_reg = 64'd1092;
  logic [63:0] damping_reg = 64'd65536;
  wide_t accel_reg[3] = '{default: '0};
  wide_t track_pos[3] = '{default: '0};
  wide_t track_vel[3] = '{default: '0};
  wide_t track_force[3] = '{default: '0};
  bit item_clipped;

  particle_euler_integrator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_z(vel_z),
    .saturated(saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic wide_t clamp_word(input wide_t v);
    if (v > WORD_HI) begin
      item_clipped = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      item_clipped = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  // Magnitude times factor, rounded half away from zero, then clipped to the word.
  function automatic wide_t scaled_product(input wide_t a, input logic [63:0] factor,
                                           input int shift);
    logic [127:0] mag;
    logic [63:0] ua;
    logic [63:0] lim;
    wide_t m;
    bit neg;
    neg = (a < 0);
    ua = neg ? 64'(-a) : 64'(a);
    mag = {64'd0, ua} * {64'd0, factor};
    mag = (mag + (128'd1 << (shift - 1))) >> shift;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > {64'd0, lim}) begin
      item_clipped = 1'b1;
      mag = {64'd0, lim};
    end
    m = wide_t'(mag[63:0]);
    return neg ? -m : m;
  endfunction

  function automatic motion_state_t advance_particle(input motion_cmd_t c);
    wide_t comp[3];
    wide_t acc;
    wide_t vel_mid;
    motion_state_t r;
    item_clipped = 1'b0;
    comp[0] = {{32{c.x[31]}}, c.x};
    comp[1] = {{32{c.y[31]}}, c.y};
    comp[2] = {{32{c.z[31]}}, c.z};
    case (c.op)
      pei_pkg::OP_FORCE: begin
        for (int i = 0; i < 3; i++) track_force[i] = clamp_word(track_force[i] + comp[i]);
      end
      pei_pkg::OP_INTEG: begin
        if (inv_mass_reg != 0) begin
          for (int i = 0; i < 3; i++) begin
            track_pos[i] = clamp_word(track_pos[i] +
                scaled_product(track_vel[i], time_step_reg, SCALE_BITS));
            acc = clamp_word(accel_reg[i] +
                scaled_product(track_force[i], inv_mass_reg, SCALE_BITS));
            vel_mid = clamp_word(track_vel[i] +
                scaled_product(acc, time_step_reg, SCALE_BITS));
            track_vel[i] = scaled_product(vel_mid, damping_reg, pei_pkg::DAMP_BITS);
            track_force[i] = '0;
          end
        end
      end
      pei_pkg::OP_SET_POS: begin
        for (int i = 0; i < 3; i++) track_pos[i] = comp[i];
      end
      default: begin
        for (int i = 0; i < 3; i++) track_vel[i] = comp[i];
      end
    endcase
    r.pos_x = track_pos[0][31:0];
    r.pos_y = track_pos[1][31:0];
    r.pos_z = track_pos[2][31:0];
    r.vel_x = track_vel[0][31:0];
    r.vel_y = track_vel[1][31:0];
    r.vel_z = track_vel[2][31:0];
    r.saturated = item_clipped;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_states.push_back(advance_particle({opcode, vec_x, vec_y, vec_z}));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          opcode <= next_cmd.op;
          vec_x <= next_cmd.x;
          vec_y <= next_cmd.y;
          vec_z <= next_cmd.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated};
      if (expected_states.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = expected_states.pop_front();
        if (got.pos_x !== want.pos_x)
          report_mismatch($sformatf("pos_x got %h want %h", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
          report_mismatch($sformatf("pos_y got %h want %h", got.pos_y, want.pos_y));
        if (got.pos_z !== want.pos_z)
          report_mismatch($sformatf("pos_z got %h want %h", got.pos_z, want.pos_z));
        if (got.vel_x !== want.vel_x)
          report_mismatch($sformatf("vel_x got %h want %h", got.vel_x, want.vel_x));
        if (got.vel_y !== want.vel_y)
          report_mismatch($sformatf("vel_y got %h want %h", got.vel_y, want.vel_y));
        if (got.vel_z !== want.vel_z)
          report_mismatch($sformatf("vel_z got %h want %h", got.vel_z, want.vel_z));
        if (got.saturated !== want.saturated)
          report_mismatch($sformatf("saturated got %b want %b", got.saturated,
                                    want.saturated));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [31:0] wild_comp();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] mild_comp();
    return 32'($urandom_range(0, 2 * MILD_SPAN) - MILD_SPAN);
  endfunction

  task automatic push_cmd(input logic [pei_pkg::OP_W-1:0] op, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
    pending_cmds.push_back({op, x, y, z});
    issued_count++;
  endtask

  task automatic wait_idle();
    while (!(accepted_count == issued_count && expected_states.size() == 0))
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [pei_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pei_pkg::REG_INV_MASS: inv_mass_reg = {33'd0, data[30:0]};
      pei_pkg::REG_ACCEL_X: accel_reg[0] = {{32{data[31]}}, data};
      pei_pkg::REG_ACCEL_Y: accel_reg[1] = {{32{data[31]}}, data};
      pei_pkg::REG_ACCEL_Z: accel_reg[2] = {{32{data[31]}}, data};
      pei_pkg::REG_TIME_STEP: time_step_reg = {47'd0, data[16:0]};
      pei_pkg::REG_DAMPING: damping_reg = {47'd0, data[16:0]};
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_segment(input int seg);
    logic [31:0] inv;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] ts;
    logic [31:0] damp;
    case (seg)
      0: begin
        inv = 32'd0;
        ax = 32'h7FFF_FFFF;
        ay = 32'h8000_0000;
        az = 32'd0;
        ts = 32'd65536;
        damp = 32'd65536;
      end
      1: begin
        inv = 32'hFFFF_FFFF;
        ax = 32'h8000_0000;
        ay = 32'h7FFF_FFFF;
        az = mild_comp();
        ts = 32'hFFFF_FFFF;
        damp = 32'hFFFF_FFFF;
      end
      2: begin
        inv = 32'd1;
        ax = mild_comp();
        ay = mild_comp();
        az = mild_comp();
        ts = 32'd0;
        damp = 32'd0;
      end
      3: begin
        inv = 32'd65536;
        ax = mild_comp();
        ay = mild_comp();
        az = mild_comp();
        ts = 32'd1;
        damp = 32'd65535;
      end
      default: begin
        inv = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 4 << 16);
        ax = ($urandom_range(3) == 0) ? wild_comp() : mild_comp();
        ay = ($urandom_range(3) == 0) ? wild_comp() : mild_comp();
        az = ($urandom_range(3) == 0) ? wild_comp() : mild_comp();
        ts = ($urandom_range(3) == 0) ? $urandom_range(0, 131071) : $urandom_range(1, 65536);
        damp = ($urandom_range(3) == 0) ? $urandom_range(0, 131071)
                                        : $urandom_range(60000, 65536);
        if ($urandom_range(3) == 0) begin
          inv[31] = 1'b1;
          ts[31:17] = 15'($urandom());
          damp[31:17] = 15'($urandom());
        end
      end
    endcase
    write_reg(pei_pkg::REG_INV_MASS, inv);
    write_reg(pei_pkg::REG_ACCEL_X, ax);
    write_reg(pei_pkg::REG_ACCEL_Y, ay);
    write_reg(pei_pkg::REG_ACCEL_Z, az);
    write_reg(pei_pkg::REG_TIME_STEP, ts);
    write_reg(pei_pkg::REG_DAMPING, damp);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
  endtask

  // Mostly short flights: load a state, gather forces, then take a few steps.
  task automatic queue_segment(input int count);
    int start;
    int n;
    start = issued_count;
    while (issued_count - start < count) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(1))
          push_cmd(pei_pkg::OP_SET_POS, mild_comp(), mild_comp(), mild_comp());
        if ($urandom_range(1))
          push_cmd(pei_pkg::OP_SET_VEL, mild_comp(), mild_comp(), mild_comp());
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(4) == 0)
            push_cmd(pei_pkg::OP_FORCE, wild_comp(), wild_comp(), wild_comp());
          else
            push_cmd(pei_pkg::OP_FORCE, mild_comp(), mild_comp(), mild_comp());
        end
        n = $urandom_range(1, 4);
        repeat (n) push_cmd(pei_pkg::OP_INTEG, $urandom(), $urandom(), $urandom());
      end else begin
        push_cmd(pei_pkg::OP_W'($urandom_range(3)), wild_comp(), wild_comp(), wild_comp());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 80;
    push_cmd(pei_pkg::OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_SET_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_cmd(pei_pkg::OP_SET_VEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    push_cmd(pei_pkg::OP_INTEG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_cmd(pei_pkg::OP_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_SET_VEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cmd(pei_pkg::OP_SET_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_FORCE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cmd(pei_pkg::OP_FORCE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_SET_POS, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_SET_VEL, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    push_cmd(pei_pkg::OP_FORCE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_7FFF);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    push_cmd(pei_pkg::OP_SET_VEL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    push_cmd(pei_pkg::OP_INTEG, 32'h0, 32'h0, 32'h0);
    wait_idle();
    for (int seg = 0; seg < 9; seg++) begin
      program_segment(seg);
      if (seg < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 80;
      end else if (seg < 6) begin
        send_idle_pct = 80;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_segment(125);
      wait_idle();
    end
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[particle_euler_integrator_top.f]
hdl/pei_pkg.sv
hdl/pei_lane.sv
hdl/pei_merge.sv
hdl/particle_euler_integrator_top.sv
verif/particle_euler_integrator_top_tb.sv
